>>> rtl/core/bwlpd_pkg.sv
package bwlpd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // config register widths
  localparam int SIZE_W = 11;
  localparam int PAT_W  = 9;
  localparam int CFG_W  = SIZE_W;
  localparam int IDX_W  = 3;

  // wide enough for the raw size register and for either maximum
  localparam int DIM_A = (SIZE_W > $clog2(MAX_WIDTH + 1)) ? SIZE_W : $clog2(MAX_WIDTH + 1);
  localparam int DIM_W = (DIM_A > $clog2(MAX_HEIGHT + 1)) ? DIM_A : $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W   = 32;
  localparam int COORD_W = 10;
  localparam int PIDX_W  = 2;
  localparam int NUM_PAT = 4;

  localparam logic [PIX_W-1:0] WHITE_PIXEL = 32'hFFFF_FFFF;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  localparam logic [PAT_W-1:0] PAT0_RST = 9'd56;
  localparam logic [PAT_W-1:0] PAT1_RST = 9'd146;
  localparam logic [PAT_W-1:0] PAT2_RST = 9'd273;
  localparam logic [PAT_W-1:0] PAT3_RST = 9'd84;

  // keeps columns 0 and 1 of each window row after the shift
  localparam logic [PAT_W-1:0] WIN_KEEP = 9'h0DB;

  // fifo depth for results: one in flight plus two waiting
  localparam int RES_DEPTH = 3;
  localparam int RES_CNT_W = 2;
  localparam int RES_PTR_W = 2;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [PIDX_W-1:0]  pattern_index;
  } res_t;

  // line store entry: upper row bit, lower row bit
  typedef struct packed {
    logic upper;
    logic lower;
  } line_t;

endpackage

>>> rtl/core/bwlpd_if.sv
interface bwlpd_pix_if;
  logic                  valid;
  logic                  ready;
  logic [31:0]           pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface bwlpd_res_if;
  logic                  valid;
  logic                  ready;
  logic [9:0]            center_x;
  logic [9:0]            center_y;
  logic [1:0]            pattern_index;

  modport source (output valid, output center_x, output center_y, output pattern_index,
                  input ready);
  modport sink (input valid, input center_x, input center_y, input pattern_index,
                output ready);
endinterface

>>> rtl/core/bwlpd_ram.sv
module bwlpd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bwlpd_result_fifo.sv
module bwlpd_result_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bwlpd_pkg::res_t            push_data,
  output logic [bwlpd_pkg::RES_CNT_W-1:0] count,
  bwlpd_res_if.source                out_res
);
  import bwlpd_pkg::*;

  res_t                 slot_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic                 pop;

  function automatic logic [RES_PTR_W-1:0] ptr_inc(input logic [RES_PTR_W-1:0] p);
    if (p == RES_PTR_W'(RES_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + RES_PTR_W'(1);
    end
  endfunction

  assign pop = out_res.valid && out_res.ready;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + RES_CNT_W'(push) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign count                 = count_r;
  assign out_res.valid         = (count_r != '0);
  assign out_res.center_x      = slot_r[rd_ptr_r].center_x;
  assign out_res.center_y      = slot_r[rd_ptr_r].center_y;
  assign out_res.pattern_index = slot_r[rd_ptr_r].pattern_index;

endmodule

>>> rtl/core/binary_window_line_pattern_detect.sv
// channel  | port     | dir | payload
// pixels   | in_pix   | in  | pixel_value[31:0]
// matches  | out_res  | out | center_x[9:0], center_y[9:0], pattern_index[1:0]
// config   | cfg_*    | in  | cfg_index[2:0], cfg_data[10:0]
//
// one pixel per cycle while in_pix.ready is high; matches are queued for out_res
// the line store ram is read on the pixel beat and written back the next cycle
// in_pix.ready drops only when the three-entry result queue could overflow
// synchronous reset, no clearing pass: line store entries are written before use
module binary_window_line_pattern_detect (
  input  logic                          clk,
  input  logic                          rst_n,
  bwlpd_pix_if.sink                     in_pix,
  bwlpd_res_if.source                   out_res,
  input  logic                          cfg_we,
  input  logic [bwlpd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bwlpd_pkg::CFG_W-1:0]   cfg_data
);
  import bwlpd_pkg::*;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_PAT0   = 3'd2,
    REG_PAT1   = 3'd3,
    REG_PAT2   = 3'd4,
    REG_PAT3   = 3'd5
  } reg_idx_t;

  logic [DIM_W-1:0] width_r, height_r;
  logic [PAT_W-1:0] pat_r [NUM_PAT];
  logic [DIM_W-1:0] cfg_dim;
  logic             size_wr;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;

  logic             s1_v_r;
  logic             s1_cur_r;
  logic [COL_W-1:0] s1_x_r;
  logic [ROW_W-1:0] s1_y_r;

  logic [PAT_W-1:0] win_r, win_nxt;
  line_t            rd_line, wr_line;

  logic             accept;
  logic             cur;
  logic             hit;
  logic [PIDX_W-1:0] hit_idx;
  res_t             res;
  logic [RES_CNT_W-1:0] res_count;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    if (v < DIM_W'(3)) begin
      clamp_dim = DIM_W'(3);
    end else if (v > hi) begin
      clamp_dim = hi;
    end else begin
      clamp_dim = v;
    end
  endfunction

  assign cfg_dim = DIM_W'(cfg_data);
  assign size_wr = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // config registers: sizes are stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      pat_r[0] <= PAT0_RST;
      pat_r[1] <= PAT1_RST;
      pat_r[2] <= PAT2_RST;
      pat_r[3] <= PAT3_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= clamp_dim(cfg_dim, DIM_W'(MAX_WIDTH));
        REG_HEIGHT: height_r <= clamp_dim(cfg_dim, DIM_W'(MAX_HEIGHT));
        REG_PAT0:   pat_r[0] <= cfg_data[PAT_W-1:0];
        REG_PAT1:   pat_r[1] <= cfg_data[PAT_W-1:0];
        REG_PAT2:   pat_r[2] <= cfg_data[PAT_W-1:0];
        REG_PAT3:   pat_r[3] <= cfg_data[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // room for the item in flight plus the one taken now
  assign in_pix.ready = (RES_CNT_W'(res_count) + RES_CNT_W'(s1_v_r)) <= RES_CNT_W'(RES_DEPTH - 1);
  assign accept       = in_pix.valid && in_pix.ready;
  assign cur          = (in_pix.pixel_value != WHITE_PIXEL);

  // raster position of the next pixel
  always_comb begin
    col_inc = DIM_W'(col_r) + DIM_W'(1);
    row_inc = DIM_W'(row_r) + DIM_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= height_r) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || size_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1 follows the ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r <= cur;
      s1_x_r   <= col_r;
      s1_y_r   <= row_r;
    end
  end

  bwlpd_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_x_r),
    .wdata (wr_line),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_line)
  );

  // the lower row moves up, the current pixel becomes the lower row
  assign wr_line.upper = rd_line.lower;
  assign wr_line.lower = s1_cur_r;

  assign win_nxt = ((win_r >> 1) & WIN_KEEP)
                 | (PAT_W'(rd_line.upper) << 2)
                 | (PAT_W'(rd_line.lower) << 5)
                 | (PAT_W'(s1_cur_r) << 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  // first template in order wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = NUM_PAT - 1; k >= 0; k--) begin
      if (win_nxt == pat_r[k]) begin
        hit     = 1'b1;
        hit_idx = PIDX_W'(k);
      end
    end
  end

  assign res.center_x      = COORD_W'(s1_x_r - COL_W'(1));
  assign res.center_y      = COORD_W'(s1_y_r - ROW_W'(1));
  assign res.pattern_index = hit_idx;

  bwlpd_result_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r && hit && (s1_x_r >= COL_W'(2)) && (s1_y_r >= ROW_W'(2))),
    .push_data (res),
    .count     (res_count),
    .out_res   (out_res)
  );

endmodule
